>>> sv/fltic_pkg.sv
// ----------------------------------------------------------------------------
// fltic_pkg
// Shared types and constants for the line-to-image fitting core.
// ----------------------------------------------------------------------------
package fltic_pkg;

   localparam int unsigned MAX_LINES_DEF = 64;
   localparam logic [12:0] SIZE_RESET    = 13'd1024;

   localparam int unsigned NUM_W = 53;
   localparam int unsigned DEN_W = 39;
   localparam int unsigned QUO_W = 13;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic [23:0]        line_color;
      logic               last_item;
   } req_type;

   typedef struct packed {
      logic [11:0] pixel_start_x;
      logic [11:0] pixel_start_y;
      logic [11:0] pixel_end_x;
      logic [11:0] pixel_end_y;
      logic [23:0] out_color;
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic        degenerate;
      logic        overflowed;
      logic        last_line;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_RANGE,
      ST_WMUL,
      ST_WDIV,
      ST_READ,
      ST_DIFF,
      ST_MUL,
      ST_SUM,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

>>> sv/fltic_div.sv
// ----------------------------------------------------------------------------
// fltic_div
// Restoring divider, one quotient bit per cycle, quotient below 2**QUO_W.
// ----------------------------------------------------------------------------
module fltic_div
   import fltic_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUM_W-1:0]   num,
   input  logic [DEN_W-1:0]   den,
   output logic               done,
   output logic [QUO_W-1:0]   quo
);

   localparam int unsigned SH_W  = DEN_W + QUO_W - 1;
   localparam int unsigned CNT_W = $clog2(QUO_W);

   logic              busy_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [NUM_W-1:0]  rem_ff;
   logic [SH_W-1:0]   dsh_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic              ge_in;
   logic              done_ff;

   assign ge_in = rem_ff >= NUM_W'(dsh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
      if (start) begin
         rem_ff <= num;
         dsh_ff <= {den, {(QUO_W-1){1'b0}}};
         cnt_ff <= CNT_W'(QUO_W - 1);
         quo_ff <= '0;
      end else if (busy_ff) begin
         if (ge_in) begin
            rem_ff <= rem_ff - NUM_W'(dsh_ff);
         end
         quo_ff <= {quo_ff[QUO_W-2:0], ge_in};
         dsh_ff <= dsh_ff >> 1;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

>>> sv/fit_lines_to_image_core.sv
// ----------------------------------------------------------------------------
// fit_lines_to_image_core
// Stores line segments, fits their bounding box to the image, emits pixels.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid/req_ready, one line per request, and are taken
// one per cycle while loading. Up to MAX_LINES lines are kept; further lines
// are dropped and flagged in every response of that set. A request with
// last_item set starts the fit: two divisions give width and height, then each
// stored line takes a memory read, then per endpoint a subtract, a multiply, a
// sum and a division on the shared restoring divider. A zero-size box skips
// all of that arithmetic.
// One response per stored line goes out on rsp_valid/rsp_ready in arrival order;
// last_line marks the end.
// No request is taken from the last_item request until the final response is
// taken. A stalled response simply holds; the core waits on it.
// csr_we/csr_wdata set image_size (reset 1024); write it only while idle.
// Reset is synchronous and returns the core to loading with an empty set.
// ----------------------------------------------------------------------------
module fit_lines_to_image_core
   import fltic_pkg::*;
#(
   parameter int unsigned MAX_LINES = MAX_LINES_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [12:0] csr_wdata
);

   localparam int unsigned CNT_W = $clog2(MAX_LINES + 1);
   localparam int unsigned IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

   state_type state_ff, state_in;
   state_type state_prev_ff;

   logic [12:0]        size_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               ovf_ff;
   logic signed [31:0] xmin_ff, xmax_ff, ymin_ff, ymax_ff;
   logic [32:0]        xr_ff, yr_ff, m_ff;
   logic [45:0]        szxr_ff, szyr_ff;
   logic               sel_ff;
   logic [12:0]        w_ff, h_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [1:0]         ep_ff;
   logic signed [34:0] tdiff_ff;
   logic signed [48:0] prod_ff;
   logic               neg_ff;
   logic [11:0]        pix_ff [4];

   logic [127:0]       ep_mem [MAX_LINES];
   logic [23:0]        col_mem [MAX_LINES];
   logic [127:0]       rd_ep_ff;
   logic [23:0]        rd_col_ff;

   logic               accept;
   logic               room;
   logic               degen;
   logic               wkick;
   logic               div_start;
   logic [NUM_W-1:0]   div_num;
   logic [DEN_W-1:0]   div_den;
   logic               div_done;
   logic [QUO_W-1:0]   div_quo;
   logic               last_idx;
   logic signed [31:0] lox, hix, loy, hiy;
   logic signed [31:0] p_sel, lo_sel, hi_sel;
   logic signed [34:0] mul_b;
   logic signed [53:0] n_sum;
   logic [45:0]        szr_sel;
   logic [DEN_W-1:0]   den40;

   assign accept   = req_valid && req_ready;
   assign room     = count_ff < CNT_W'(MAX_LINES);
   assign degen    = m_ff == '0;
   assign last_idx = CNT_W'(idx_ff) == count_ff - 1'b1;

   assign lox = (req_data.start_x < req_data.end_x) ? req_data.start_x : req_data.end_x;
   assign hix = (req_data.start_x < req_data.end_x) ? req_data.end_x : req_data.start_x;
   assign loy = (req_data.start_y < req_data.end_y) ? req_data.start_y : req_data.end_y;
   assign hiy = (req_data.start_y < req_data.end_y) ? req_data.end_y : req_data.start_y;

   assign p_sel   = $signed(rd_ep_ff[ep_ff*32 +: 32]);
   assign lo_sel  = ep_ff[0] ? ymin_ff : xmin_ff;
   assign hi_sel  = ep_ff[0] ? ymax_ff : xmax_ff;
   assign szr_sel = ep_ff[0] ? szyr_ff : szxr_ff;
   assign den40   = DEN_W'({m_ff, 5'd0}) + DEN_W'({m_ff, 3'd0});

   assign mul_b = (state_ff == ST_WMUL) ? $signed({2'b00, (sel_ff ? yr_ff : xr_ff)})
                                        : tdiff_ff;
   assign n_sum = (54'(prod_ff) <<< 4) + (54'(prod_ff) <<< 1) + 54'(prod_ff)
                + $signed({4'd0, szr_sel, 4'd0}) + $signed({6'd0, szr_sel, 2'd0})
                + $signed(54'({m_ff, 4'd0})) + $signed(54'({m_ff, 2'd0}));

   // width/height division starts on the first ST_WDIV cycle, with the product already registered
   assign wkick = (state_ff == ST_WDIV) && (state_prev_ff == ST_WMUL);

   assign div_num = (state_ff == ST_WDIV) ? NUM_W'(prod_ff[45:0]) : NUM_W'(n_sum);
   assign div_den = (state_ff == ST_WDIV) ? DEN_W'(m_ff) : den40;

   fltic_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (accept && req_data.last_item) begin
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: state_in = ST_WMUL;
         ST_WMUL: begin
            if (degen) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_WDIV;
            end
         end
         ST_WDIV: begin
            div_start = wkick;
            if (div_done) begin
               state_in = sel_ff ? ST_READ : ST_WMUL;
            end
         end
         ST_READ: state_in = degen ? ST_OUT : ST_DIFF;
         ST_DIFF: state_in = ST_MUL;
         ST_MUL:  state_in = ST_SUM;
         ST_SUM: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = (ep_ff == 2'd3) ? ST_OUT : ST_DIFF;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = last_idx ? ST_LOAD : ST_READ;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_prev_ff <= ST_LOAD;
      end else begin
         state_prev_ff <= state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         size_ff  <= SIZE_RESET;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         sel_ff   <= 1'b0;
         idx_ff   <= '0;
         ep_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            size_ff <= csr_wdata;
         end
         case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  if (room) begin
                     count_ff <= count_ff + 1'b1;
                  end else begin
                     ovf_ff <= 1'b1;
                  end
               end
               sel_ff <= 1'b0;
               idx_ff <= '0;
            end
            ST_WDIV: begin
               if (div_done) begin
                  sel_ff <= 1'b1;
               end
            end
            ST_READ: ep_ff <= '0;
            ST_DIV: begin
               if (div_done) begin
                  ep_ff <= ep_ff + 1'b1;
               end
            end
            ST_OUT: begin
               if (rsp_ready) begin
                  if (last_idx) begin
                     count_ff <= '0;
                     ovf_ff   <= 1'b0;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept && room) begin
         ep_mem[count_ff[IDX_W-1:0]]  <= {req_data.end_y, req_data.end_x,
                                          req_data.start_y, req_data.start_x};
         col_mem[count_ff[IDX_W-1:0]] <= req_data.line_color;
         if (count_ff == '0) begin
            xmin_ff <= lox;
            xmax_ff <= hix;
            ymin_ff <= loy;
            ymax_ff <= hiy;
         end else begin
            if (lox < xmin_ff) xmin_ff <= lox;
            if (hix > xmax_ff) xmax_ff <= hix;
            if (loy < ymin_ff) ymin_ff <= loy;
            if (hiy > ymax_ff) ymax_ff <= hiy;
         end
      end
      if (state_ff == ST_READ) begin
         rd_ep_ff  <= ep_mem[idx_ff];
         rd_col_ff <= col_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_RANGE: begin
            xr_ff <= {xmax_ff[31], xmax_ff} - {xmin_ff[31], xmin_ff};
            yr_ff <= {ymax_ff[31], ymax_ff} - {ymin_ff[31], ymin_ff};
            if (({xmax_ff[31], xmax_ff} - {xmin_ff[31], xmin_ff}) >
                ({ymax_ff[31], ymax_ff} - {ymin_ff[31], ymin_ff})) begin
               m_ff <= {xmax_ff[31], xmax_ff} - {xmin_ff[31], xmin_ff};
            end else begin
               m_ff <= {ymax_ff[31], ymax_ff} - {ymin_ff[31], ymin_ff};
            end
            w_ff <= '0;
            h_ff <= '0;
         end
         ST_WMUL, ST_MUL: prod_ff <= $signed({1'b0, size_ff}) * mul_b;
         ST_WDIV: begin
            if (div_done) begin
               if (sel_ff) begin
                  h_ff    <= div_quo;
                  szyr_ff <= prod_ff[45:0];
               end else begin
                  w_ff    <= div_quo;
                  szxr_ff <= prod_ff[45:0];
               end
            end
         end
         ST_READ: begin
            for (int i = 0; i < 4; i++) begin
               pix_ff[i] <= '0;
            end
         end
         ST_DIFF: tdiff_ff <= (35'(p_sel) <<< 1) - 35'(lo_sel) - 35'(hi_sel);
         ST_SUM: begin
            neg_ff <= n_sum[53];
         end
         ST_DIV: begin
            if (div_done) begin
               if (neg_ff) begin
                  pix_ff[ep_ff] <= '0;
               end else if (div_quo[QUO_W-1]) begin
                  pix_ff[ep_ff] <= 12'hFFF;
               end else begin
                  pix_ff[ep_ff] <= div_quo[11:0];
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_data.pixel_start_x = pix_ff[0];
      rsp_data.pixel_start_y = pix_ff[1];
      rsp_data.pixel_end_x   = pix_ff[2];
      rsp_data.pixel_end_y   = pix_ff[3];
      rsp_data.out_color     = rd_col_ff;
      rsp_data.image_width   = w_ff;
      rsp_data.image_height  = h_ff;
      rsp_data.degenerate    = degen;
      rsp_data.overflowed    = ovf_ff;
      rsp_data.last_line     = last_idx;
   end

endmodule

>>> tb/sv/fit_lines_to_image_core_tb.sv
// ----------------------------------------------------------------------------
// fit_lines_to_image_core_tb
// Self-checking bench for the line-to-image fitting core.
// ----------------------------------------------------------------------------
// Line sets are pushed through the request channel with random gaps while the
// response side stalls at random; the last sets run with neither. A behavioral
// fit model predicts each response unless a directed row gives its own. First
// a short directed table, then random sets: clustered, full-range, zero-size,
// horizontal and over-capacity. image_size changes between sets while idle.
// ----------------------------------------------------------------------------
module fit_lines_to_image_core_tb;
   import fltic_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = MAX_LINES_DEF;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [12:0] csr_wdata;

   fit_lines_to_image_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // fit model state
   logic signed [31:0] lines_sx[CAPACITY], lines_sy[CAPACITY];
   logic signed [31:0] lines_ex[CAPACITY], lines_ey[CAPACITY];
   logic [23:0]        lines_color[CAPACITY];
   longint             box_xlo, box_xhi, box_ylo, box_yhi;
   int                 stored_lines;
   bit                 dropped_any;
   logic [12:0]        model_size;

   rsp_type pixel_lines_due[$];
   int      fail_count;
   bit      gaps_on;
   bit      stalls_on;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } table_row_type;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("fit_lines_to_image_core_tb: FAIL");
      $finish;
   end

   function automatic logic [11:0] pixel_of(longint p, longint lo, longint hi,
                                            longint r, longint m, longint sz);
      longint n, d, q;
      n = 20 * sz * r + 19 * sz * (2 * p - lo - hi);
      d = 40 * m;
      if (n <= 0 || d <= 0) return 12'd0;
      q = (2 * n + d) / (2 * d);
      if (q > 4095) q = 4095;
      return q[11:0];
   endfunction

   function automatic void fit_accept(req_type r);
      longint  sx, sy, ex, ey, xr, yr, m, sz, w, h;
      rsp_type o;
      sx = longint'(r.start_x); sy = longint'(r.start_y);
      ex = longint'(r.end_x);   ey = longint'(r.end_y);
      if (stored_lines < CAPACITY) begin
         lines_sx[stored_lines] = r.start_x; lines_sy[stored_lines] = r.start_y;
         lines_ex[stored_lines] = r.end_x;   lines_ey[stored_lines] = r.end_y;
         lines_color[stored_lines] = r.line_color;
         if (stored_lines == 0) begin
            box_xlo = (sx < ex) ? sx : ex; box_xhi = (sx > ex) ? sx : ex;
            box_ylo = (sy < ey) ? sy : ey; box_yhi = (sy > ey) ? sy : ey;
         end else begin
            if (sx < box_xlo) box_xlo = sx;
            if (ex < box_xlo) box_xlo = ex;
            if (sx > box_xhi) box_xhi = sx;
            if (ex > box_xhi) box_xhi = ex;
            if (sy < box_ylo) box_ylo = sy;
            if (ey < box_ylo) box_ylo = ey;
            if (sy > box_yhi) box_yhi = sy;
            if (ey > box_yhi) box_yhi = ey;
         end
         stored_lines++;
      end else begin
         dropped_any = 1'b1;
      end
      if (!r.last_item) return;
      xr = box_xhi - box_xlo;
      yr = box_yhi - box_ylo;
      m  = (xr > yr) ? xr : yr;
      sz = longint'(model_size);
      w  = (m == 0) ? 0 : (sz * xr) / m;
      h  = (m == 0) ? 0 : (sz * yr) / m;
      for (int k = 0; k < stored_lines; k++) begin
         o = '0;
         if (m != 0) begin
            o.pixel_start_x = pixel_of(lines_sx[k], box_xlo, box_xhi, xr, m, sz);
            o.pixel_start_y = pixel_of(lines_sy[k], box_ylo, box_yhi, yr, m, sz);
            o.pixel_end_x   = pixel_of(lines_ex[k], box_xlo, box_xhi, xr, m, sz);
            o.pixel_end_y   = pixel_of(lines_ey[k], box_ylo, box_yhi, yr, m, sz);
         end
         o.out_color    = lines_color[k];
         o.image_width  = w[12:0];
         o.image_height = h[12:0];
         o.degenerate   = (m == 0);
         o.overflowed   = dropped_any;
         o.last_line    = (k + 1 == stored_lines);
         pixel_lines_due.push_back(o);
      end
      stored_lines = 0;
      dropped_any  = 1'b0;
      box_xlo = 0; box_xhi = 0; box_ylo = 0; box_yhi = 0;
   endfunction

   // call right after a rising edge
   task automatic send_line(req_type r, bit typed = 1'b0, rsp_type want = '0);
      bit took;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do begin
         @(negedge clock);
         took = req_valid && req_ready;
         @(posedge clock);
      end while (!took);
      fit_accept(r);
      if (typed) begin
         void'(pixel_lines_due.pop_back());
         pixel_lines_due.push_back(want);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pixel_lines_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_size(logic [12:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      model_size = v;
   endtask

   // random-content line; style picks the coordinate spread
   function automatic req_type random_line(int style, logic [31:0] base);
      req_type r;
      r.line_color = 24'($urandom);
      r.last_item  = 1'b0;
      case (style)
         0: begin
            r.start_x = $urandom; r.start_y = $urandom;
            r.end_x   = $urandom; r.end_y   = $urandom;
         end
         1: begin
            r.start_x = base + $urandom_range(0, 32'h000F_FFFF);
            r.start_y = base - $urandom_range(0, 32'h000F_FFFF);
            r.end_x   = base + $urandom_range(0, 32'h000F_FFFF);
            r.end_y   = base - $urandom_range(0, 32'h000F_FFFF);
         end
         2: begin
            r.start_x = base; r.start_y = ~base;
            r.end_x   = base; r.end_y   = ~base;
         end
         default: begin
            r.start_x = base + $urandom_range(0, 32'h00FF_FFFF);
            r.start_y = base;
            r.end_x   = base + $urandom_range(0, 32'h00FF_FFFF);
            r.end_y   = base;
         end
      endcase
      return r;
   endfunction

   always @(negedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixel_lines_due.size() == 0) begin
            $error("response with none expected: %h", rsp_data);
            fail_count++;
         end else begin
            e = pixel_lines_due.pop_front();
            if (rsp_data.pixel_start_x !== e.pixel_start_x) begin
               $error("pixel_start_x exp %0d got %0d", e.pixel_start_x, rsp_data.pixel_start_x);
               fail_count++;
            end
            if (rsp_data.pixel_start_y !== e.pixel_start_y) begin
               $error("pixel_start_y exp %0d got %0d", e.pixel_start_y, rsp_data.pixel_start_y);
               fail_count++;
            end
            if (rsp_data.pixel_end_x !== e.pixel_end_x) begin
               $error("pixel_end_x exp %0d got %0d", e.pixel_end_x, rsp_data.pixel_end_x);
               fail_count++;
            end
            if (rsp_data.pixel_end_y !== e.pixel_end_y) begin
               $error("pixel_end_y exp %0d got %0d", e.pixel_end_y, rsp_data.pixel_end_y);
               fail_count++;
            end
            if (rsp_data.out_color !== e.out_color) begin
               $error("out_color exp %h got %h", e.out_color, rsp_data.out_color);
               fail_count++;
            end
            if (rsp_data.image_width !== e.image_width) begin
               $error("image_width exp %0d got %0d", e.image_width, rsp_data.image_width);
               fail_count++;
            end
            if (rsp_data.image_height !== e.image_height) begin
               $error("image_height exp %0d got %0d", e.image_height, rsp_data.image_height);
               fail_count++;
            end
            if (rsp_data.degenerate !== e.degenerate) begin
               $error("degenerate exp %0d got %0d", e.degenerate, rsp_data.degenerate);
               fail_count++;
            end
            if (rsp_data.overflowed !== e.overflowed) begin
               $error("overflowed exp %0d got %0d", e.overflowed, rsp_data.overflowed);
               fail_count++;
            end
            if (rsp_data.last_line !== e.last_line) begin
               $error("last_line exp %0d got %0d", e.last_line, rsp_data.last_line);
               fail_count++;
            end
         end
      end
   end

   // response back-pressure
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stalls_on && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   initial begin
      table_row_type rows[$];
      table_row_type t;
      req_type       r;
      int            sent, set_len, style;
      logic [31:0]   base;
      logic [12:0]   sizes[$];

      reset = 1'b1; req_valid = 1'b0; req_data = '0;
      csr_we = 1'b0; csr_wdata = '0;
      fail_count = 0; gaps_on = 1'b1; stalls_on = 1'b1;
      stored_lines = 0; dropped_any = 1'b0; model_size = SIZE_RESET;
      box_xlo = 0; box_xhi = 0; box_ylo = 0; box_yhi = 0;

      // zero-size box
      t.req = '{32'sh0005_0000, 32'sh0005_0000, 32'sh0005_0000, 32'sh0005_0000,
                24'hFFFFFF, 1'b1};
      t.typed = 1'b1;
      t.want = '{12'd0, 12'd0, 12'd0, 12'd0, 24'hFFFFFF, 13'd0, 13'd0, 1'b1, 1'b0, 1'b1};
      rows.push_back(t);
      // unit horizontal line at reset size: 1024*1/40 and 1024*39/40
      t.req = '{32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0, 24'h000000, 1'b1};
      t.want = '{12'd26, 12'd0, 12'd998, 12'd0, 24'h000000, 13'd1024, 13'd0,
                 1'b0, 1'b0, 1'b1};
      rows.push_back(t);
      t.typed = 1'b0;
      t.want  = '0;
      // full-range corners
      t.req = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                24'hA5A5A5, 1'b0};
      rows.push_back(t);
      t.req = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                24'h5A5A5A, 1'b1};
      rows.push_back(t);
      // vertical set, zero x range
      t.req = '{-32'sh0003_0000, -32'sh0002_0000, -32'sh0003_0000, 32'sh0004_8000,
                24'h123456, 1'b0};
      rows.push_back(t);
      t.req = '{-32'sh0003_0000, 32'sh0001_0000, -32'sh0003_0000, 32'sh0000_0001,
                24'h654321, 1'b1};
      rows.push_back(t);
      // tall box, mixed signs
      t.req = '{32'sh0001_8000, -32'sh0010_0000, -32'sh0000_4000, 32'sh0020_0000,
                24'h00FF00, 1'b0};
      rows.push_back(t);
      t.req = '{32'sh0000_0000, 32'sh0000_0000, 32'sh0000_FFFF, 32'sh0000_0001,
                24'hFF0000, 1'b0};
      rows.push_back(t);
      t.req = '{-32'sh0000_0001, 32'sh0001_0000, 32'sh0002_0000, -32'sh0001_0000,
                24'h0000FF, 1'b1};
      rows.push_back(t);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_line(rows[i].req, rows[i].typed, rows[i].want);
      wait_idle();

      sizes = '{13'd1, 13'd4096, 13'd8191, 13'd0, 13'd640, 13'd1024};
      sent = 0;
      while (sent < 420) begin
         if ($urandom_range(0, 4) == 0) begin
            if (sizes.size() != 0) write_size(sizes.pop_front());
            else write_size(13'($urandom_range(1, 4096)));
         end
         if (sent > 370) begin
            gaps_on = 1'b0;
            stalls_on = 1'b0;
         end
         set_len = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70)
                                                : $urandom_range(1, 8);
         style = $urandom_range(0, 9);
         style = (style < 2) ? 0 : (style < 3) ? 2 : (style < 4) ? 3 : 1;
         base  = $urandom;
         for (int k = 0; k < set_len; k++) begin
            r = random_line(style, base);
            r.last_item = (k == set_len - 1);
            send_line(r);
            sent++;
         end
         wait_idle();
      end

      if (fail_count == 0 && pixel_lines_due.size() == 0) begin
         $display("fit_lines_to_image_core_tb: PASS");
      end else begin
         $display("fit_lines_to_image_core_tb: FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
sv/fltic_pkg.sv
sv/fltic_div.sv
sv/fit_lines_to_image_core.sv
tb/sv/fit_lines_to_image_core_tb.sv
